@@ rtl/core/indexed_list_insert_remove_assert.svh @@
// Assertion macros for the indexed list block.
// ILIR_ASSERT_NOW : antecedent implies consequent in the same cycle.
// ILIR_ASSERT_NEXT: antecedent implies consequent in the next cycle.
// Both sample on clk and are off while arst_n is low.
`ifndef INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH

`ifndef SYNTHESIS

`define ILIR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ILIR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ILIR_ASSERT_NOW(lbl, ante, cons, msg)

`define ILIR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/core/ilir_pkg.sv @@
`timescale 1ns / 1ps

package ilir_pkg;

	typedef enum logic [2:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_GET    = 3'd2,
		OP_SET    = 3'd3,
		OP_INSERT = 3'd4,
		OP_REMOVE = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_RANGE = 2'd1,
		ERR_FULL  = 2'd2
	} err_t;

	// per-cell move
	typedef enum logic [1:0] {
		ACT_HOLD    = 2'd0,
		ACT_LOAD    = 2'd1,
		ACT_FROM_LO = 2'd2,
		ACT_FROM_HI = 2'd3
	} cell_act_t;

endpackage

@@ rtl/core/ilir_cell.sv @@
`timescale 1ns / 1ps

module ilir_cell #(
	parameter int unsigned W = 32
) (
	input  logic                clk,
	input  ilir_pkg::cell_act_t act,
	input  logic [W-1:0]        wr_data,
	input  logic [W-1:0]        lo_data,
	input  logic [W-1:0]        hi_data,
	output logic [W-1:0]        data_q
);
	import ilir_pkg::*;

	always_ff @(posedge clk) begin
		unique case (act)
			ACT_HOLD:    data_q <= data_q;
			ACT_LOAD:    data_q <= wr_data;
			ACT_FROM_LO: data_q <= lo_data;   // insert: shift up
			ACT_FROM_HI: data_q <= hi_data;   // remove: shift down
			default:     data_q <= data_q;
		endcase
	end

endmodule

@@ rtl/core/indexed_list_insert_remove.sv @@
`timescale 1ns / 1ps
// Channel | Handshake          | Fields
// --------+--------------------+----------------------------------------
// in      | in_valid, in_stall | opcode[2:0], index[4:0], value[31:0]
// out     | out_valid,out_stall| ok, error_code[1:0], read_value[31:0], length[4:0]
//
// One item per cycle while the output is not stalled: every cell of the
// chain loads, holds or takes a neighbor's word at the same edge, so an
// insert or remove takes no longer than any other item, regardless of
// index. The result is registered. Reset clears the fill count and the
// output valid; entries stay unknown until written. A stalled result holds;
// a new item is taken in the cycle the waiting result leaves.

`include "indexed_list_insert_remove_assert.svh"

module indexed_list_insert_remove #(
	parameter int unsigned DEPTH     = 16,
	parameter int unsigned ELEM_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [4:0]  index,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [1:0]  error_code,
	output logic [31:0] read_value,
	output logic [4:0]  length
);
	import ilir_pkg::*;

	// fill count width, compare width, cell address width
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned IW = (CW > 5) ? CW : 5;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned VW = (ELEM_BITS > 32) ? ELEM_BITS : 32;
	localparam logic [IW-1:0] DEPTH_E = IW'(DEPTH);

	logic                 in_acc;
	logic [CW-1:0]        fill_q;
	logic [IW-1:0]        fill_e;
	logic [IW-1:0]        idx_e;
	logic [IW-1:0]        fill_nx_e;
	logic [IW-1:0]        sel_e;
	logic [AW-1:0]        rd_addr;
	logic [VW-1:0]        val_ext;
	logic [ELEM_BITS-1:0] wr_word;
	logic [ELEM_BITS-1:0] rd_word;
	logic [VW-1:0]        rd_ext;

	logic  op_ok, rd_en;
	err_t  op_err;
	logic  push_ok, pop_ok, set_ok, ins_ok, rem_ok;

	logic [ELEM_BITS-1:0] cell_q [DEPTH];
	cell_act_t            act    [DEPTH];

	logic        out_valid_q;
	logic        ok_q;
	err_t        err_q;
	logic [31:0] rd_q;
	logic [4:0]  len_q;

	// output register frees up in the cycle its item is taken
	assign in_stall = out_valid_q & out_stall;
	assign in_acc   = in_valid & ~in_stall;

	assign fill_e  = IW'(fill_q);
	assign idx_e   = IW'(index);
	assign val_ext = VW'(value);
	assign wr_word = val_ext[ELEM_BITS-1:0];

	// opcode decode and range checks
	always_comb begin
		op_ok   = 1'b0;
		op_err  = ERR_RANGE;
		rd_en   = 1'b0;
		sel_e   = idx_e;
		push_ok = 1'b0;
		pop_ok  = 1'b0;
		set_ok  = 1'b0;
		ins_ok  = 1'b0;
		rem_ok  = 1'b0;
		unique case (opcode_t'(opcode))
			OP_PUSH: begin
				if (fill_e >= DEPTH_E) begin
					op_err = ERR_FULL;
				end else begin
					push_ok = 1'b1;
				end
			end
			OP_POP: begin
				sel_e = IW'(fill_e - 1'b1);
				if (fill_e != '0) begin
					pop_ok = 1'b1;
					rd_en  = 1'b1;
				end
			end
			OP_GET: begin
				if (idx_e < fill_e) begin
					op_ok = 1'b1;
					rd_en = 1'b1;
				end
			end
			OP_SET: begin
				if (idx_e < fill_e) begin
					set_ok = 1'b1;
				end
			end
			OP_INSERT: begin
				// index check goes ahead of the full check
				if (idx_e > fill_e) begin
					op_err = ERR_RANGE;
				end else if (fill_e >= DEPTH_E) begin
					op_err = ERR_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (idx_e < fill_e) begin
					rem_ok = 1'b1;
					rd_en  = 1'b1;
				end
			end
			default: begin
				op_err = ERR_RANGE;
			end
		endcase
		if (push_ok || pop_ok || set_ok || ins_ok || rem_ok) begin
			op_ok = 1'b1;
		end
		if (op_ok) begin
			op_err = ERR_NONE;
		end
	end

	always_comb begin
		fill_nx_e = fill_e;
		if (push_ok || ins_ok) begin
			fill_nx_e = IW'(fill_e + 1'b1);
		end else if (pop_ok || rem_ok) begin
			fill_nx_e = IW'(fill_e - 1'b1);
		end
	end

	// read port: one word out of the chain, only where in range
	assign rd_addr = sel_e[AW-1:0];
	assign rd_word = rd_en ? cell_q[rd_addr] : '0;
	assign rd_ext  = VW'(rd_word);

	// chain of cells; each one decides its own move from its position
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [IW-1:0] POS  = IW'(i);
		localparam logic [IW-1:0] POS1 = IW'(i + 1);
		logic [ELEM_BITS-1:0] lo_d;
		logic [ELEM_BITS-1:0] hi_d;

		if (i == 0) begin : g_lo_edge
			assign lo_d = cell_q[i];
		end else begin : g_lo
			assign lo_d = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_hi_edge
			assign hi_d = cell_q[i];
		end else begin : g_hi
			assign hi_d = cell_q[i+1];
		end

		always_comb begin
			act[i] = ACT_HOLD;
			if (in_acc) begin
				priority if ((push_ok && fill_e == POS) ||
					((set_ok || ins_ok) && idx_e == POS)) begin
					act[i] = ACT_LOAD;
				end else if (ins_ok && POS > idx_e && POS <= fill_e) begin
					act[i] = ACT_FROM_LO;
				end else if (rem_ok && POS >= idx_e && POS1 < fill_e) begin
					act[i] = ACT_FROM_HI;
				end else begin
					act[i] = ACT_HOLD;
				end
			end
		end

		ilir_cell #(
			.W (ELEM_BITS)
		) u_cell (
			.clk     (clk),
			.act     (act[i]),
			.wr_data (wr_word),
			.lo_data (lo_d),
			.hi_data (hi_d),
			.data_q  (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (in_acc) begin
			fill_q <= fill_nx_e[CW-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ok_q  <= op_ok;
			err_q <= op_err;
			rd_q  <= rd_ext[31:0];
			len_q <= fill_nx_e[4:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign error_code = err_q;
	assign read_value = rd_q;
	assign length     = len_q;

	// checks
	`ILIR_ASSERT_NOW(a_fill_bound, 1'b1, fill_e <= DEPTH_E, "fill count above depth")
	`ILIR_ASSERT_NOW(a_ok_no_err, out_valid_q && ok_q, err_q == ERR_NONE, "ok with error code")
	`ILIR_ASSERT_NEXT(a_push_grows, in_acc && push_ok, fill_q == CW'($past(fill_q) + 1'b1), "push did not grow list")
	`ILIR_ASSERT_NEXT(a_len_match, in_acc, out_valid_q && len_q == fill_e[4:0], "length differs from fill count")

endmodule
